[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define ILNS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent in the cycle after the antecedent
`define ILNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/ilns_pkg.sv]
`default_nettype none
package ilns_pkg;

  localparam int VALUE_WIDTH   = 16;
  localparam int COUNT_WIDTH   = 16;
  localparam int REV_WIDTH     = VALUE_WIDTH + 4;
  localparam int D_WIDTH       = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH      = 2 * D_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
  localparam int UPC_WIDTH     = 4;

  // divide by ten as a multiply by the rounded-up reciprocal and a shift
  localparam int                     TEN_SHIFT = VALUE_WIDTH + 3;
  localparam logic [VALUE_WIDTH-1:0] TEN_RECIP =
    VALUE_WIDTH'(((64'd1 << TEN_SHIFT) + 64'd9) / 64'd10);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   last_item;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] largest;
    logic [VALUE_WIDTH-1:0] smallest;
    logic [COUNT_WIDTH-1:0] prime_count;
    logic [COUNT_WIDTH-1:0] palindrome_count;
    logic [VALUE_WIDTH-1:0] most_divisors_value;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT,
    OP_DIV_D,
    OP_TALLY,
    OP_DEC,
    OP_DIV_TEN,
    OP_DIGIT,
    OP_FOLD,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BELOW_TWO,
    COND_SQ_ABOVE,
    COND_DIV_BUSY,
    COND_REST_ZERO,
    COND_NOT_LAST,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t                  op;
    cond_t                cond;
    logic [UPC_WIDTH-1:0] target;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic below_two;
    logic sq_above;
    logic div_busy;
    logic rest_zero;
    logic not_last;
    logic out_blocked;
  } status_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic [VALUE_WIDTH-1:0] remainder;
  } div_rsp_t;

  // program step addresses
  localparam logic [UPC_WIDTH-1:0] S_IDLE   = 4'd0;
  localparam logic [UPC_WIDTH-1:0] S_INIT   = 4'd1;
  localparam logic [UPC_WIDTH-1:0] S_DLOOP  = 4'd2;
  localparam logic [UPC_WIDTH-1:0] S_DSTART = 4'd3;
  localparam logic [UPC_WIDTH-1:0] S_DWAIT  = 4'd4;
  localparam logic [UPC_WIDTH-1:0] S_TALLY  = 4'd5;
  localparam logic [UPC_WIDTH-1:0] S_DEC    = 4'd6;
  localparam logic [UPC_WIDTH-1:0] S_PLOOP  = 4'd7;
  localparam logic [UPC_WIDTH-1:0] S_PSTART = 4'd8;
  localparam logic [UPC_WIDTH-1:0] S_DIGIT  = 4'd9;
  localparam logic [UPC_WIDTH-1:0] S_FOLD   = 4'd10;
  localparam logic [UPC_WIDTH-1:0] S_HOLD   = 4'd11;
  localparam logic [UPC_WIDTH-1:0] S_EMIT   = 4'd12;

  // control store: jump to target when the condition holds, else fall through
  function automatic uword_t ucode(input logic [UPC_WIDTH-1:0] addr);
    uword_t w;
    case (addr)
      S_IDLE:   w = '{OP_ACCEPT,  COND_NO_INPUT,    S_IDLE};
      S_INIT:   w = '{OP_INIT,    COND_BELOW_TWO,   S_PLOOP};
      S_DLOOP:  w = '{OP_NOP,     COND_SQ_ABOVE,    S_DEC};
      S_DSTART: w = '{OP_DIV_D,   COND_NONE,        S_IDLE};
      S_DWAIT:  w = '{OP_NOP,     COND_DIV_BUSY,    S_DWAIT};
      S_TALLY:  w = '{OP_TALLY,   COND_ALWAYS,      S_DLOOP};
      S_DEC:    w = '{OP_DEC,     COND_NONE,        S_IDLE};
      S_PLOOP:  w = '{OP_NOP,     COND_REST_ZERO,   S_FOLD};
      S_PSTART: w = '{OP_DIV_TEN, COND_NONE,        S_IDLE};
      S_DIGIT:  w = '{OP_DIGIT,   COND_ALWAYS,      S_PLOOP};
      S_FOLD:   w = '{OP_FOLD,    COND_NOT_LAST,    S_IDLE};
      S_HOLD:   w = '{OP_NOP,     COND_OUT_BLOCKED, S_HOLD};
      S_EMIT:   w = '{OP_EMIT,    COND_ALWAYS,      S_IDLE};
      default:  w = '{OP_NOP,     COND_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/integer_list_number_statistics_top.sv]
// list statistics engine
// input channel (in_valid/in_ready/in_data) takes one list element per
// transaction; in_data.last_item marks the final element of a list
// output channel (out_valid/out_ready/out_data) carries one transaction per
// list: largest, smallest, prime count, palindrome count and the element
// with the most proper divisors (larger element wins a tie)
// one element is processed at a time; in_ready is high only while the
// sequencer sits in its idle step
// each trial divisor is one pass through the 16-step bit-serial remainder
// unit, each decimal digit one pass through a reciprocal multiply; 0 and 1
// skip the trial division
// the last element adds a hold and an emit step: hold waits while the result
// register is full and not taken, then emit loads it and sets out_valid
// a stalled receiver holds the result; the next list is processed meanwhile
// and its emit step waits until the previous result is taken
// reset (rst_n low, synchronous) clears the running statistics, the
// sequencer and the result valid flag; no clearing pass is needed
`default_nettype none
module integer_list_number_statistics_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ilns_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ilns_pkg::out_item_t      out_data
);
  import ilns_pkg::*;

  // microcode step currently driving the datapath
  op_t      op;
  // datapath flags the jump conditions look at
  status_t  status;
  // remainder unit handshake
  div_req_t div_req;
  div_rsp_t div_rsp;

  // program counter and control store
  ilns_sequencer u_sequencer (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  // element registers, statistics and result register
  ilns_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .status    (status)
  );

  // bit-serial remainder unit for the trial division
  ilns_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
`default_nettype wire

[hw/rtl/ilns_divider.sv]
`default_nettype none
module ilns_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ilns_pkg::div_req_t req,
  output ilns_pkg::div_rsp_t     rsp
);
  import ilns_pkg::*;

  localparam logic [DIV_CNT_WIDTH-1:0] CNT_LAST = DIV_CNT_WIDTH'(VALUE_WIDTH - 1);

  logic                     busy_r, busy_nxt;
  logic [DIV_CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0]   rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0]   quo_r, quo_nxt;
  logic [VALUE_WIDTH-1:0]   dvs_r, dvs_nxt;
  logic [VALUE_WIDTH:0]     shifted;
  logic [VALUE_WIDTH:0]     diff;
  logic                     fits;

  // one restoring step per cycle
  assign shifted = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
      quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

[hw/rtl/ilns_sequencer.sv]
`default_nettype none
module ilns_sequencer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ilns_pkg::status_t status,
  output ilns_pkg::op_t         op
);
  import ilns_pkg::*;

  logic [UPC_WIDTH-1:0] upc_r, upc_nxt;
  uword_t               word;
  logic                 take;

  assign word = ucode(upc_r);

  always_comb begin
    case (word.cond)
      COND_NONE:        take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_INPUT:    take = status.no_input;
      COND_BELOW_TWO:   take = status.below_two;
      COND_SQ_ABOVE:    take = status.sq_above;
      COND_DIV_BUSY:    take = status.div_busy;
      COND_REST_ZERO:   take = status.rest_zero;
      COND_NOT_LAST:    take = status.not_last;
      COND_OUT_BLOCKED: take = status.out_blocked;
      default:          take = 1'b1;
    endcase
    upc_nxt = take ? word.target : upc_r + 1'b1;
  end

  always_comb begin
    op = word.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ilns_datapath.sv]
`default_nettype none
module ilns_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ilns_pkg::op_t      op,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ilns_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ilns_pkg::out_item_t     out_data,
  output ilns_pkg::div_req_t      div_req,
  input  wire ilns_pkg::div_rsp_t div_rsp,
  output ilns_pkg::status_t       status
);
  import ilns_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] TWO = VALUE_WIDTH'(2);

  // current item
  logic [VALUE_WIDTH-1:0] v_r;
  logic                   last_r;
  // divisor scan and digit reversal
  logic [D_WIDTH-1:0]     d_r;
  logic [VALUE_WIDTH-1:0] total_r;
  logic [VALUE_WIDTH-1:0] rest_r;
  logic [VALUE_WIDTH-1:0] ten_quo_r;
  logic [REV_WIDTH-1:0]   rev_r;
  // running statistics
  logic [VALUE_WIDTH-1:0] max_r, min_r, best_val_r, best_tot_r;
  logic [COUNT_WIDTH-1:0] primes_r, pals_r;
  logic                   started_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  logic [SQ_WIDTH-1:0]      d_sq;
  logic [SQ_WIDTH-1:0]      v_wide;
  logic [REV_WIDTH-1:0]     rev_times_ten;
  logic                     is_pal;
  logic [2*VALUE_WIDTH-1:0] ten_prod;
  logic [VALUE_WIDTH-1:0]   ten_quo;
  logic [VALUE_WIDTH-1:0]   quo_times_ten;
  logic [VALUE_WIDTH-1:0]   digit;

  assign d_sq          = SQ_WIDTH'(d_r) * SQ_WIDTH'(d_r);
  assign v_wide        = SQ_WIDTH'(v_r);
  assign rev_times_ten = {rev_r[REV_WIDTH-4:0], 3'b000} + {rev_r[REV_WIDTH-2:0], 1'b0};
  assign is_pal        = rev_r == REV_WIDTH'(v_r);

  // rest / 10 by reciprocal, registered; the digit is what the quotient leaves
  assign ten_prod      = (2*VALUE_WIDTH)'(rest_r) * (2*VALUE_WIDTH)'(TEN_RECIP);
  assign ten_quo       = VALUE_WIDTH'(ten_prod >> TEN_SHIFT);
  assign quo_times_ten = {ten_quo_r[VALUE_WIDTH-4:0], 3'b000} +
                         {ten_quo_r[VALUE_WIDTH-2:0], 1'b0};
  assign digit         = rest_r - quo_times_ten;

  assign in_ready  = op == OP_ACCEPT;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    div_req.start    = op == OP_DIV_D;
    div_req.dividend = v_r;
    div_req.divisor  = VALUE_WIDTH'(d_r);
  end

  always_comb begin
    status.no_input    = !in_valid;
    status.below_two   = v_r < TWO;
    status.sq_above    = d_sq > v_wide;
    status.div_busy    = div_rsp.busy;
    status.rest_zero   = rest_r == '0;
    status.not_last    = !last_r;
    status.out_blocked = out_valid_r && !out_ready;
  end

  // work registers
  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: begin
        if (in_valid) begin
          v_r    <= in_data.value;
          last_r <= in_data.last_item;
        end
      end
      OP_INIT: begin
        d_r     <= D_WIDTH'(1);
        total_r <= '0;
        rest_r  <= v_r;
        rev_r   <= '0;
      end
      OP_TALLY: begin
        if (div_rsp.remainder == '0) begin
          total_r <= total_r + ((d_sq != v_wide) ? VALUE_WIDTH'(2) : VALUE_WIDTH'(1));
        end
        d_r <= d_r + 1'b1;
      end
      OP_DEC: begin
        total_r <= total_r - 1'b1;
      end
      OP_DIV_TEN: begin
        ten_quo_r <= ten_quo;
      end
      OP_DIGIT: begin
        rev_r  <= rev_times_ten + REV_WIDTH'(digit);
        rest_r <= ten_quo_r;
      end
      default: begin
      end
    endcase
  end

  // running statistics and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= '0;
      min_r       <= '1;
      primes_r    <= '0;
      pals_r      <= '0;
      best_tot_r  <= '0;
      best_val_r  <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_FOLD: begin
          if (v_r > max_r) max_r <= v_r;
          if (v_r < min_r) min_r <= v_r;
          if (total_r == VALUE_WIDTH'(1) && primes_r != '1) primes_r <= primes_r + 1'b1;
          if (is_pal && pals_r != '1) pals_r <= pals_r + 1'b1;
          if (!started_r || total_r > best_tot_r) begin
            best_tot_r <= total_r;
            best_val_r <= v_r;
          end else if (total_r == best_tot_r && v_r > best_val_r) begin
            best_val_r <= v_r;
          end
          started_r <= 1'b1;
        end
        OP_EMIT: begin
          max_r       <= '0;
          min_r       <= '1;
          primes_r    <= '0;
          pals_r      <= '0;
          best_tot_r  <= '0;
          best_val_r  <= '0;
          started_r   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_data_r.largest             <= max_r;
      out_data_r.smallest            <= min_r;
      out_data_r.prime_count         <= primes_r;
      out_data_r.palindrome_count    <= pals_r;
      out_data_r.most_divisors_value <= best_val_r;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ilns_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module ilns_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire ilns_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire ilns_pkg::out_item_t out_data
);
  import ilns_pkg::*;

  logic in_take;
  assign in_take = in_valid && in_ready && (in_data.last_item || !in_data.last_item);

  // a stalled result holds
  `ILNS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // one element at a time: ready drops right after a transaction
  `ILNS_ASSERT_NEXT(a_in_single, in_take, !in_ready)
  // extremes are consistent
  `ILNS_ASSERT_SAME(a_min_le_max, out_valid, out_data.smallest <= out_data.largest)
  // the chosen element lies within the extremes
  `ILNS_ASSERT_SAME(a_best_range, out_valid,
                    out_data.most_divisors_value >= out_data.smallest &&
                    out_data.most_divisors_value <= out_data.largest)

endmodule

bind integer_list_number_statistics_top ilns_checker u_checker (.*);
`default_nettype wire
